FILE: rtl/ifsr_pkg.sv
// Shared types, constants and arithmetic helpers of the image fit size resolver.
package ifsr_pkg;

	// Field widths.
	localparam int DIM_BITS   = 16;
	localparam int FRAC_BITS  = 4;
	localparam int LEN_BITS   = DIM_BITS + FRAC_BITS;
	// Intermediate lengths can reach 2^DIM_BITS, so they carry one extra bit.
	localparam int VAL_BITS   = DIM_BITS + 1;
	localparam int PROD_BITS  = 2 * VAL_BITS;
	localparam int NUM_BITS   = PROD_BITS + 1;
	localparam int DEN_BITS   = VAL_BITS + 1;
	localparam int QUO_BITS   = VAL_BITS;
	// One preparation stage, then one quotient bit per stage.
	localparam int DIV_STAGES = QUO_BITS + 1;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONTAINER_WIDTH = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_VIEWPORT_HEIGHT = CFG_IDX_BITS'(1);
	localparam logic [DIM_BITS-1:0] CONTAINER_WIDTH_RST = DIM_BITS'(480);
	localparam logic [DIM_BITS-1:0] VIEWPORT_HEIGHT_RST = DIM_BITS'(800);

	typedef struct packed {
		logic [DIM_BITS-1:0] intrinsic_width;
		logic [DIM_BITS-1:0] intrinsic_height;
		logic                has_css_width;
		logic                has_css_height;
		logic [LEN_BITS-1:0] css_width_px;
		logic [LEN_BITS-1:0] css_height_px;
	} req_word_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] display_width;
		logic [DIM_BITS-1:0] display_height;
	} rsp_word_t;

	typedef enum logic [1:0] {
		BR_BOTH   = 2'd0,
		BR_HEIGHT = 2'd1,
		BR_WIDTH  = 2'd2,
		BR_FIT    = 2'd3
	} branch_t;

	// Facts carried alongside the division for the final selection.
	typedef struct packed {
		branch_t             br;
		logic                keep;
		logic                xsel;
		logic                hcl;
		logic [VAL_BITS-1:0] fw;
		logic [VAL_BITS-1:0] fh;
	} side_t;

	typedef struct packed {
		logic [PROD_BITS-1:0] num_a;
		logic [VAL_BITS-1:0]  den_a;
		logic [PROD_BITS-1:0] num_b;
		logic [VAL_BITS-1:0]  den_b;
		logic                 rnd;
		side_t                side;
	} div_req_t;

	typedef struct packed {
		logic [QUO_BITS-1:0] quo_a;
		logic [QUO_BITS-1:0] quo_b;
		side_t               side;
	} div_rsp_t;

	typedef struct packed {
		logic [NUM_BITS-1:0] rem;
		logic [DEN_BITS-1:0] den;
		logic [QUO_BITS-1:0] quo;
		logic                ovf;
	} lane_t;

	// Round a Q.FRAC_BITS length to whole pixels, half up.
	function automatic logic [VAL_BITS-1:0] round_len(input logic [LEN_BITS-1:0] q);
		logic [LEN_BITS+1:0] s;
		s = {1'b0, q, 1'b0} + ((LEN_BITS+2)'(1) << FRAC_BITS);
		return VAL_BITS'(s >> (FRAC_BITS + 1));
	endfunction

	function automatic logic [VAL_BITS-1:0] max1(input logic [VAL_BITS-1:0] v);
		return (v == '0) ? VAL_BITS'(1) : v;
	endfunction

	function automatic logic [DIM_BITS-1:0] sat(input logic [VAL_BITS-1:0] v);
		return v[VAL_BITS-1] ? '1 : v[DIM_BITS-1:0];
	endfunction

	// Set up a division; rounding uses (2n + d) / (2d).
	function automatic lane_t div_prep(input logic [PROD_BITS-1:0] p,
			input logic [VAL_BITS-1:0] d, input logic rnd);
		lane_t l;
		l.rem = rnd ? (NUM_BITS'({p, 1'b0}) + NUM_BITS'(d)) : NUM_BITS'(p);
		l.den = rnd ? {d, 1'b0} : {1'b0, d};
		l.quo = '0;
		l.ovf = {1'b0, l.rem} >= ((NUM_BITS+1)'(l.den) << QUO_BITS);
		return l;
	endfunction

	// One restoring step producing quotient bit bitpos.
	function automatic lane_t div_step(input lane_t l, input int bitpos);
		lane_t r;
		logic [NUM_BITS-1:0] trial;
		logic take;
		r = l;
		trial = NUM_BITS'(l.den) << bitpos;
		take = l.rem >= trial;
		if (take) begin
			r.rem = l.rem - trial;
		end
		r.quo = {l.quo[QUO_BITS-2:0], take};
		return r;
	endfunction

endpackage

FILE: rtl/ifsr_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
module ifsr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ifsr_pkg::div_req_t in_req,
	output logic              out_valid,
	input  logic              out_ready,
	output ifsr_pkg::div_rsp_t out_rsp
);
	import ifsr_pkg::*;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   en;
	lane_t lane_a_s [DIV_STAGES];
	lane_t lane_b_s [DIV_STAGES];
	side_t side_s   [DIV_STAGES];
	lane_t nxt_a    [DIV_STAGES];
	lane_t nxt_b    [DIV_STAGES];
	side_t nxt_side [DIV_STAGES];
	logic  src_vld  [DIV_STAGES];

	// A stage moves when it is empty or the one after it moves.
	assign en[DIV_STAGES] = out_ready;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
		assign en[k] = !vld_s[k] || en[k+1];

		if (k == 0) begin : g_prep
			always_comb begin
				nxt_a[k]    = div_prep(in_req.num_a, in_req.den_a, in_req.rnd);
				nxt_b[k]    = div_prep(in_req.num_b, in_req.den_b, in_req.rnd);
				nxt_side[k] = in_req.side;
				src_vld[k]  = in_valid;
			end
		end else begin : g_bit
			always_comb begin
				nxt_a[k]    = div_step(lane_a_s[k-1], QUO_BITS - k);
				nxt_b[k]    = div_step(lane_b_s[k-1], QUO_BITS - k);
				nxt_side[k] = side_s[k-1];
				src_vld[k]  = vld_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= src_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_vld[k]) begin
				lane_a_s[k] <= nxt_a[k];
				lane_b_s[k] <= nxt_b[k];
				side_s[k]   <= nxt_side[k];
			end
		end
	end

	// Quotients that do not fit are pinned to all ones.
	assign in_ready      = en[0];
	assign out_valid     = vld_s[DIV_STAGES-1];
	assign out_rsp.quo_a = lane_a_s[DIV_STAGES-1].ovf ? '1 : lane_a_s[DIV_STAGES-1].quo;
	assign out_rsp.quo_b = lane_b_s[DIV_STAGES-1].ovf ? '1 : lane_b_s[DIV_STAGES-1].quo;
	assign out_rsp.side  = side_s[DIV_STAGES-1];

	// The final remainder is below the divisor unless the quotient overflowed.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lane_a_s[DIV_STAGES-1].ovf ||
			lane_a_s[DIV_STAGES-1].rem < NUM_BITS'(lane_a_s[DIV_STAGES-1].den)))
		else $error("divider lane a remainder out of range");

	// An empty first stage always takes a word.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[0] |-> in_ready)
		else $error("divider refused a word with an empty first stage");

	// A full pipeline with a stalled receiver takes nothing.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_s) && !out_ready |-> !in_ready)
		else $error("divider took a word while full and stalled");

endmodule

FILE: rtl/image_fit_size_resolver.sv
// Top level of the image fit size resolver: branch decode, scale pick and result selection.
//
// Use: each request word carries an image's natural size, two flags for requested
// width and height and those lengths in pixels (unsigned Q16.4). Each response word
// carries the displayed width and height. Both channels use valid and ready; a word
// moves at a rising edge where both are high.
// Configuration: container width (index 0) and viewport height (index 1) are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while no
// request is in flight, as the block itself does not enforce this.
// A word passes 24 registers: five front stages, the 18-stage divider (one preparation
// stage and one quotient bit per stage) and the output register; the first loads at the
// accepting edge. Throughput: one word per cycle while rsp_ready is high; every stage,
// the divider included, takes a new word each cycle unless the stage after it is stalled.
// Reset: asynchronous, active low; all stages empty, registers at 480 and 800.
// Stall: when the receiver holds ready low the response waits in the output register
// and words close up behind it, so request ready drops only once every stage is full.
module image_fit_size_resolver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ifsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ifsr_pkg::DIM_BITS-1:0]         cfg_data,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  ifsr_pkg::req_word_t                   req_word,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output ifsr_pkg::rsp_word_t                   rsp_word
);
	import ifsr_pkg::*;

	logic [DIM_BITS-1:0] cw_q, vh_q;
	logic [VAL_BITS-1:0] cw17, vh17;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= CONTAINER_WIDTH_RST;
			vh_q <= VIEWPORT_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONTAINER_WIDTH: cw_q <= cfg_data;
				CFG_VIEWPORT_HEIGHT: vh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cw17 = {1'b0, cw_q};
	assign vh17 = {1'b0, vh_q};

	// Stage handshake: a stage moves when empty or when the next one moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic div_in_ready, div_out_valid;
	div_rsp_t div_rsp;

	assign en6       = !v_s6 || rsp_ready;
	assign en5       = !v_s5 || div_in_ready;
	assign en4       = !v_s4 || en5;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= div_out_valid;
		end
	end

	// Stage 1: branch decode and rounding of the requested lengths.
	branch_t br_c1;
	branch_t br_s1;
	logic [DIM_BITS-1:0] iw_s1, ih_s1;
	logic [VAL_BITS-1:0] rw_s1, rh_s1;

	always_comb begin
		logic known;
		known = (req_word.intrinsic_width != '0) && (req_word.intrinsic_height != '0);
		priority if (req_word.has_css_width && req_word.has_css_height && known) begin
			br_c1 = BR_BOTH;
		end else if (req_word.has_css_height && !req_word.has_css_width && known) begin
			br_c1 = BR_HEIGHT;
		end else if (req_word.has_css_width && !req_word.has_css_height && known) begin
			br_c1 = BR_WIDTH;
		end else begin
			br_c1 = BR_FIT;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			br_s1 <= br_c1;
			iw_s1 <= req_word.intrinsic_width;
			ih_s1 <= req_word.intrinsic_height;
			rw_s1 <= round_len(req_word.css_width_px);
			rh_s1 <= round_len(req_word.css_height_px);
		end
	end

	// Stage 2: minimums, first clamps and limit compares.
	branch_t br_s2;
	logic [DIM_BITS-1:0] iw_s2, ih_s2;
	logic [VAL_BITS-1:0] w0_s2, h0_s2, vx_s2, vy_s2, h1_s2, w1_s2;
	logic xgt_s2, ygt_s2, hcl_s2;

	always_ff @(posedge clk) begin
		logic [VAL_BITS-1:0] w0, h0, vx, vy;
		if (en2 && v_s1) begin
			w0 = max1(rw_s1);
			h0 = max1(rh_s1);
			vx = (br_s1 == BR_BOTH) ? w0 : {1'b0, iw_s1};
			vy = (br_s1 == BR_BOTH) ? h0 : {1'b0, ih_s1};
			br_s2  <= br_s1;
			iw_s2  <= iw_s1;
			ih_s2  <= ih_s1;
			w0_s2  <= w0;
			h0_s2  <= h0;
			vx_s2  <= vx;
			vy_s2  <= vy;
			xgt_s2 <= vx > cw17;
			ygt_s2 <= vy > vh17;
			hcl_s2 <= h0 > vh17;
			h1_s2  <= (h0 > vh17) ? vh17 : h0;
			w1_s2  <= max1((rw_s1 > cw17) ? cw17 : rw_s1);
		end
	end

	// Stage 3: per-axis factors and their cross products.
	branch_t br_s3;
	logic [DIM_BITS-1:0] iw_s3, ih_s3;
	logic [VAL_BITS-1:0] w0_s3, h0_s3, h1_s3, w1_s3;
	logic [VAL_BITS-1:0] xn_s3, xd_s3, yn_s3, yd_s3;
	logic [PROD_BITS-1:0] p1_s3, p2_s3;
	logic hcl_s3, keep_s3;

	always_ff @(posedge clk) begin
		logic [VAL_BITS-1:0] xn, xd, yn, yd;
		if (en3 && v_s2) begin
			xn = xgt_s2 ? cw17 : VAL_BITS'(1);
			xd = xgt_s2 ? vx_s2 : VAL_BITS'(1);
			yn = ygt_s2 ? vh17 : VAL_BITS'(1);
			yd = ygt_s2 ? vy_s2 : VAL_BITS'(1);
			br_s3   <= br_s2;
			iw_s3   <= iw_s2;
			ih_s3   <= ih_s2;
			w0_s3   <= w0_s2;
			h0_s3   <= h0_s2;
			h1_s3   <= h1_s2;
			w1_s3   <= w1_s2;
			hcl_s3  <= hcl_s2;
			keep_s3 <= !(xgt_s2 || ygt_s2);
			xn_s3   <= xn;
			xd_s3   <= xd;
			yn_s3   <= yn;
			yd_s3   <= yd;
			p1_s3   <= xn * yd;
			p2_s3   <= yn * xd;
		end
	end

	// Stage 4: pick the smaller factor; on a tie the vertical one wins.
	branch_t br_s4;
	logic [DIM_BITS-1:0] iw_s4, ih_s4;
	logic [VAL_BITS-1:0] w0_s4, h0_s4, h1_s4, w1_s4, n_s4, d_s4;
	logic hcl_s4, keep_s4, xsel_s4;

	always_ff @(posedge clk) begin
		logic xsel;
		if (en4 && v_s3) begin
			xsel = p1_s3 < p2_s3;
			br_s4   <= br_s3;
			iw_s4   <= iw_s3;
			ih_s4   <= ih_s3;
			w0_s4   <= w0_s3;
			h0_s4   <= h0_s3;
			h1_s4   <= h1_s3;
			w1_s4   <= w1_s3;
			hcl_s4  <= hcl_s3;
			keep_s4 <= keep_s3;
			xsel_s4 <= xsel;
			n_s4    <= xsel ? xn_s3 : yn_s3;
			d_s4    <= xsel ? xd_s3 : yd_s3;
		end
	end

	// Stage 5: divider operands and numerator products for each branch.
	div_req_t req_s5;

	always_ff @(posedge clk) begin
		logic [VAL_BITS-1:0] a1, a2, b1, b2, da, db;
		logic rnd;
		if (en5 && v_s4) begin
			unique case (br_s4)
				BR_BOTH: begin
					a1 = xsel_s4 ? h0_s4 : w0_s4;
					a2 = n_s4;
					da = d_s4;
					b1 = '0;
					b2 = '0;
					db = VAL_BITS'(1);
					rnd = 1'b1;
				end
				BR_HEIGHT: begin
					a1 = h1_s4;
					a2 = {1'b0, iw_s4};
					da = {1'b0, ih_s4};
					b1 = cw17;
					b2 = {1'b0, ih_s4};
					db = {1'b0, iw_s4};
					rnd = 1'b1;
				end
				BR_WIDTH: begin
					a1 = w1_s4;
					a2 = {1'b0, ih_s4};
					da = {1'b0, iw_s4};
					b1 = vh17;
					b2 = {1'b0, iw_s4};
					db = {1'b0, ih_s4};
					rnd = 1'b1;
				end
				BR_FIT: begin
					a1 = {1'b0, iw_s4};
					a2 = n_s4;
					da = d_s4;
					b1 = {1'b0, ih_s4};
					b2 = n_s4;
					db = d_s4;
					rnd = 1'b0;
				end
				default: begin
					a1 = '0;
					a2 = '0;
					da = VAL_BITS'(1);
					b1 = '0;
					b2 = '0;
					db = VAL_BITS'(1);
					rnd = 1'b0;
				end
			endcase
			req_s5.num_a     <= a1 * a2;
			req_s5.den_a     <= da;
			req_s5.num_b     <= b1 * b2;
			req_s5.den_b     <= db;
			req_s5.rnd       <= rnd;
			req_s5.side.br   <= br_s4;
			req_s5.side.keep <= keep_s4;
			req_s5.side.xsel <= xsel_s4;
			req_s5.side.hcl  <= hcl_s4;
			req_s5.side.fw   <= (br_s4 == BR_BOTH) ? w0_s4 : w1_s4;
			req_s5.side.fh   <= (br_s4 == BR_BOTH) ? h0_s4 : h1_s4;
		end
	end

	ifsr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_req    (req_s5),
		.out_valid (div_out_valid),
		.out_ready (en6),
		.out_rsp   (div_rsp)
	);

	// Stage 6: second clamps, minimum of one and saturation.
	rsp_word_t word_s6;

	always_ff @(posedge clk) begin
		logic [VAL_BITS-1:0] w, h, wt, qa, qb;
		if (en6 && div_out_valid) begin
			qa = div_rsp.quo_a;
			qb = div_rsp.quo_b;
			unique case (div_rsp.side.br)
				BR_BOTH: begin
					if (div_rsp.side.keep) begin
						w = div_rsp.side.fw;
						h = div_rsp.side.fh;
					end else if (div_rsp.side.xsel) begin
						w = max1(cw17);
						h = max1(qa);
					end else begin
						w = max1(qa);
						h = max1(vh17);
					end
				end
				BR_HEIGHT: begin
					wt = div_rsp.side.hcl ? max1(qa) : qa;
					if (wt > cw17) begin
						w = cw17;
						h = max1(qb);
					end else begin
						w = wt;
						h = div_rsp.side.fh;
					end
					w = max1(w);
				end
				BR_WIDTH: begin
					if (qa > vh17) begin
						h = vh17;
						w = max1(qb);
					end else begin
						h = qa;
						w = div_rsp.side.fw;
					end
					h = max1(h);
				end
				BR_FIT: begin
					w = qa;
					h = qb;
				end
				default: begin
					w = '0;
					h = '0;
				end
			endcase
			word_s6.display_width  <= sat(w);
			word_s6.display_height <= sat(h);
		end
	end

	assign rsp_valid = v_s6;
	assign rsp_word  = word_s6;

endmodule
